// File: hw/rtl/bcor_pkg.sv
`default_nettype none

package bcor_pkg;

  // Item kind carried on s_tuser
  typedef enum logic {
    OP_LOAD      = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ACC_SHIFT   = 2'd0,
    CFG_BIAS_SCALE  = 2'd1,
    CFG_FINAL_SHIFT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // Field widths
  localparam int unsigned CH_W    = 4;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned RES_W   = 8;
  localparam int unsigned CFG_D_W = 16;

  // One channel's coefficient pair
  typedef struct packed {
    logic signed [COEF_W-1:0] mult;
    logic signed [COEF_W-1:0] bias;
  } coef_t;

endpackage

`default_nettype wire

// File: hw/rtl/bcor_coef_store.sv
`default_nettype none

module bcor_coef_store #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic                       rd_en,
  input  wire logic [bcor_pkg::CH_W-1:0]  channel,
  input  wire bcor_pkg::coef_t            wr_coef,
  output bcor_pkg::coef_t                 rd_coef
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  bcor_pkg::coef_t mem [CHANNELS];
  bcor_pkg::coef_t rd_q;
  logic            hit_q;

  logic [AW+bcor_pkg::CH_W-1:0] ch_ext;
  logic [AW-1:0]                addr;
  logic                         in_range;

  // Channels past the table are ignored on load and read as zero
  assign ch_ext   = (AW + bcor_pkg::CH_W)'(channel);
  assign addr     = ch_ext[AW-1:0];
  assign in_range = (32'(channel) < CHANNELS);

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem[addr] <= wr_coef;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_q <= in_range;
      if (in_range) begin
        rd_q <= mem[addr];
      end
    end
  end

  assign rd_coef = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/binary_conv_output_requantizer.sv
`default_nettype none
// Channel   | Direction | Transfer when            | Content
// ----------+-----------+--------------------------+---------------------------------------
// s_*       | in        | s_tvalid & s_tready      | load or transform item (kind on tuser)
// m_*       | out       | m_tvalid & m_tready      | signed 8-bit activation
// cfg_*     | in        | cfg_valid & cfg_ready    | register index and write data
//
// One item per cycle while the output is not stalled; transform results pass stages 0 to 5 in turn.
// Loads write the coefficient table at their transfer and produce no result.
// rst (synchronous) resets the stage valid bits and config registers; the table is not cleared.
// Each stage holds only while the stage after it is full and stalled, so bubbles close up.

module binary_conv_output_requantizer #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] channel, [35:4] accumulator, [51:36] coef_multiplier, [67:52] coef_bias,
  // [71:68] zero
  input  wire logic [71:0] s_tdata,
  // [0] operation
  input  wire logic [0:0]  s_tuser,
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] result
  output logic [7:0]       m_tdata,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic signed [5:0]  acc_shift;
  logic signed [15:0] bias_scale;
  logic [4:0]         final_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_shift   <= 6'sd0;
      bias_scale  <= 16'sd1;
      final_shift <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (bcor_pkg::cfg_idx_t'(cfg_index))
        bcor_pkg::CFG_ACC_SHIFT:   acc_shift   <= cfg_data[5:0];
        bcor_pkg::CFG_BIAS_SCALE:  bias_scale  <= cfg_data;
        bcor_pkg::CFG_FINAL_SHIFT: final_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic                     in_fire;
  bcor_pkg::op_t            in_op;
  logic [3:0]               in_ch;
  logic signed [31:0]       in_acc;
  bcor_pkg::coef_t          in_coef;

  assign in_op        = bcor_pkg::op_t'(s_tuser[0]);
  assign in_ch        = s_tdata[3:0];
  assign in_acc       = s_tdata[35:4];
  assign in_coef.mult = s_tdata[51:36];
  assign in_coef.bias = s_tdata[67:52];

  // Per-stage valid and advance
  logic v0, v1, v2, v3, v4, v5;
  logic r0, r1, r2, r3, r4, r5;

  assign r5 = !v5 || m_tready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;

  assign s_tready = r0;
  assign in_fire  = s_tvalid && s_tready;

  // Stage 0: table lookup, accumulator capture
  bcor_pkg::coef_t    coef0;
  logic signed [31:0] acc0;

  bcor_coef_store #(
    .CHANNELS (CHANNELS)
  ) u_coef (
    .clk     (clk),
    .wr_en   (in_fire && (in_op == bcor_pkg::OP_LOAD)),
    .rd_en   (in_fire && (in_op == bcor_pkg::OP_TRANSFORM)),
    .channel (in_ch),
    .wr_coef (in_coef),
    .rd_coef (coef0)
  );

  always_ff @(posedge clk) begin
    if (r0) begin
      acc0 <= in_acc;
    end
  end

  // Stage 1: rounding shift of the accumulator, 16-bit saturation; bias product
  logic signed [63:0] acc_wide;
  logic signed [63:0] shifted;
  logic [4:0]         rs;
  logic [5:0]         ls;
  logic signed [15:0] scaled_next;
  logic signed [15:0] scaled1;
  logic signed [15:0] mult1;
  logic signed [31:0] bprod1;

  always_comb begin
    acc_wide = 64'(acc0);
    rs       = acc_shift[4:0];
    ls       = 6'(-acc_shift);
    if (!acc_shift[5] && (acc_shift != 6'sd0)) begin
      shifted = (acc_wide + (64'sd1 <<< (rs - 5'd1))) >>> rs;
    end else begin
      shifted = acc_wide <<< ls;
    end
    if (shifted > 64'sd32767) begin
      scaled_next = 16'sd32767;
    end else if (shifted < -64'sd32767) begin
      scaled_next = -16'sd32767;
    end else begin
      scaled_next = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      scaled1 <= scaled_next;
      mult1   <= coef0.mult;
      bprod1  <= 32'(coef0.bias) * 32'(bias_scale);
    end
  end

  // Stage 2: channel multiply (bias product never exceeds 2^30, so no saturation)
  logic signed [31:0] mprod2;
  logic signed [31:0] bias2;

  always_ff @(posedge clk) begin
    if (r2) begin
      mprod2 <= 32'(mult1) * 32'(scaled1);
      bias2  <= bprod1;
    end
  end

  // Stage 3: add bias, symmetric 32-bit saturation
  logic signed [32:0] sum3;
  logic signed [31:0] p3_next;
  logic signed [31:0] p3;

  always_comb begin
    sum3 = 33'(mprod2) + 33'(bias2);
    if (sum3 > 33'sd2147483647) begin
      p3_next = 32'sd2147483647;
    end else if (sum3 < -33'sd2147483647) begin
      p3_next = -32'sd2147483647;
    end else begin
      p3_next = sum3[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      p3 <= p3_next;
    end
  end

  // Stage 4: rounding shift by final_shift, symmetric 16-bit saturation
  logic signed [32:0] fsh;
  logic signed [15:0] q4_next;
  logic signed [15:0] q4;

  always_comb begin
    if (final_shift != 5'd0) begin
      fsh = (33'(p3) + (33'sd1 <<< (final_shift - 5'd1))) >>> final_shift;
    end else begin
      fsh = 33'(p3);
    end
    if (fsh > 33'sd32767) begin
      q4_next = 16'sd32767;
    end else if (fsh < -33'sd32767) begin
      q4_next = -16'sd32767;
    end else begin
      q4_next = fsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      q4 <= q4_next;
    end
  end

  // Stage 5: round by 8, clamp to int8, output register
  logic signed [16:0] r8;
  logic signed [7:0]  res_next;
  logic signed [7:0]  res5;

  always_comb begin
    r8 = (17'(q4) + 17'sd128) >>> 8;
    if (r8 > 17'sd127) begin
      res_next = 8'sd127;
    end else if (r8 < -17'sd128) begin
      res_next = -8'sd128;
    end else begin
      res_next = r8[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      res5 <= res_next;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r0) v0 <= in_fire && (in_op == bcor_pkg::OP_TRANSFORM);
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = res5;

endmodule

`default_nettype wire

// File: tb/tb_binary_conv_output_requantizer.sv
`default_nettype none

module tb_binary_conv_output_requantizer;

  localparam int CHANNELS = 16;

  // Coefficient tables, register shadow and queue of pending activations
  class requant_scoreboard;
    logic signed [bcor_pkg::COEF_W-1:0] mult_tab [CHANNELS];
    logic signed [bcor_pkg::COEF_W-1:0] bias_tab [CHANNELS];
    logic signed [5:0]                  acc_shift;
    logic signed [15:0]                 bias_scale;
    logic [4:0]                         final_shift;
    logic [bcor_pkg::RES_W-1:0]         activation_q [$];
    int unsigned                        errors;

    function new();
      acc_shift   = '0;
      bias_scale  = 16'sd1;
      final_shift = '0;
      errors      = 0;
      foreach (mult_tab[i]) begin
        mult_tab[i] = '0;
        bias_tab[i] = '0;
      end
    endfunction

    function void set_register(bcor_pkg::cfg_idx_t idx, logic [bcor_pkg::CFG_D_W-1:0] data);
      case (idx)
        bcor_pkg::CFG_ACC_SHIFT:   acc_shift   = data[5:0];
        bcor_pkg::CFG_BIAS_SCALE:  bias_scale  = data;
        bcor_pkg::CFG_FINAL_SHIFT: final_shift = data[4:0];
        default: ;  // unknown index: ignored
      endcase
    endfunction

    static function longint sat_sym(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi) return -hi;
      return v;
    endfunction

    // Round-half-up right shift; non-positive amounts shift left exactly
    static function longint round_shift(longint v, int s);
      if (s > 0) return (v + (longint'(1) << (s - 1))) >>> s;
      return v <<< (-s);
    endfunction

    function logic [bcor_pkg::RES_W-1:0] requantize(logic [bcor_pkg::CH_W-1:0] ch,
                                                    logic signed [bcor_pkg::ACC_W-1:0] acc);
      longint scaled, biased, sum, r;
      scaled = sat_sym(round_shift(longint'(acc), int'(acc_shift)), 16);
      biased = sat_sym(longint'(bias_tab[ch]) * longint'(bias_scale), 32);
      sum    = sat_sym(longint'(mult_tab[ch]) * scaled + biased, 32);
      sum    = sat_sym(round_shift(sum, int'(final_shift)), 16);
      r      = round_shift(sum, 8);
      if (r < -128) r = -128;
      if (r > 127) r = 127;
      return r[7:0];
    endfunction

    function void note_item(bcor_pkg::op_t op, logic [bcor_pkg::CH_W-1:0] ch,
                            logic signed [bcor_pkg::ACC_W-1:0] acc,
                            logic signed [bcor_pkg::COEF_W-1:0] mult,
                            logic signed [bcor_pkg::COEF_W-1:0] bias);
      if (op == bcor_pkg::OP_LOAD) begin
        mult_tab[ch] = mult;
        bias_tab[ch] = bias;
      end else begin
        activation_q.push_back(requantize(ch, acc));
      end
    endfunction

    function void check_activation(logic [bcor_pkg::RES_W-1:0] act);
      logic [bcor_pkg::RES_W-1:0] exp_act;
      if (activation_q.size() == 0) begin
        $error("result: none expected, actual %0d", $signed(act));
        errors++;
      end else begin
        exp_act = activation_q.pop_front();
        if (act !== exp_act) begin
          $error("result: expected %0d, actual %0d", $signed(exp_act), $signed(act));
          errors++;
        end
      end
    endfunction

    function int pending();
      return activation_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [3:0] channel, [35:4] accumulator, [51:36] multiplier, [67:52] bias
  logic [0:0]  s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] result
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  requant_scoreboard sb = new();

  // Sender and receiver pacing
  bit tx_gaps   = 1'b0;
  int burst_left = 0;
  int rx_style  = 0;
  int rx_hold   = 0;
  int rx_run    = 0;
  bit rx_on     = 1'b1;

  binary_conv_output_requantizer #(.CHANNELS(CHANNELS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Monitors: every transfer on the three channels
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      sb.set_register(bcor_pkg::cfg_idx_t'(cfg_index), cfg_data);
    if (!rst && s_tvalid && s_tready)
      sb.note_item(bcor_pkg::op_t'(s_tuser[0]), s_tdata[3:0], s_tdata[35:4],
                   s_tdata[51:36], s_tdata[67:52]);
    if (!rst && m_tvalid && m_tready)
      sb.check_activation(m_tdata);
  end

  // Receiver: long hold-off on request, else always ready, random, or run-length pattern
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        case (rx_style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (rx_run <= 0) begin
              rx_on  = !rx_on;
              rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            rx_run--;
            m_tready <= rx_on;
          end
        endcase
      end
    end
  end

  // Mix of extremes, small, mid-range and full-range values of a signed field
  function automatic logic [31:0] pick_value(int bits);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h1 << (bits - 1);
      1: v = ~(32'h1 << (bits - 1));
      2: v = $urandom_range(0, 1023) - 512;
      3: v = $signed($urandom()) >>> ($urandom_range(0, bits - 1) + 32 - bits);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_item(input bcor_pkg::op_t op, input logic [3:0] ch,
                           input logic [31:0] acc,
                           input logic [15:0] mult, input logic [15:0] bias);
    if (tx_gaps) begin
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'h0, bias, mult, acc, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input bcor_pkg::cfg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper data bits carry noise; the block must mask them
  task automatic apply_settings(input int shift, input int scale, input int fsh,
                                input bit poke_unused);
    logic [15:0] data;
    data = 16'($urandom());
    data[5:0] = shift[5:0];
    write_reg(bcor_pkg::CFG_ACC_SHIFT, data);
    write_reg(bcor_pkg::CFG_BIAS_SCALE, scale[15:0]);
    data = 16'($urandom());
    data[4:0] = fsh[4:0];
    write_reg(bcor_pkg::CFG_FINAL_SHIFT, data);
    if (poke_unused) write_reg(bcor_pkg::CFG_UNUSED, 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Pending results out, then a wait for the pipeline to empty
  task automatic wait_drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: coefficient extremes, then every channel loaded before use
    send_item(bcor_pkg::OP_LOAD, 4'd0, $urandom(), 16'h7fff, 16'h7fff);
    send_item(bcor_pkg::OP_LOAD, 4'd1, $urandom(), 16'h8000, 16'h8000);
    send_item(bcor_pkg::OP_LOAD, 4'd2, $urandom(), 16'h8000, 16'h7fff);
    send_item(bcor_pkg::OP_LOAD, 4'd3, $urandom(), 16'h0001, 16'h0000);
    send_item(bcor_pkg::OP_LOAD, 4'd4, $urandom(), 16'h0000, 16'hffff);
    for (int i = 5; i < CHANNELS; i++)
      send_item(bcor_pkg::OP_LOAD, 4'(i), $urandom(), 16'(pick_value(16)),
                16'(pick_value(16)));

    // Directed at reset settings: rounding boundaries and saturation
    send_item(bcor_pkg::OP_TRANSFORM, 4'd3, 32'd127, 16'($urandom()), 16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd3, 32'd128, 16'($urandom()), 16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd3, -32'sd128, 16'($urandom()), 16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd3, -32'sd129, 16'($urandom()), 16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd3, 32'h8000_0000, 16'($urandom()),
              16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd0, 32'h7fff_ffff, 16'($urandom()),
              16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd1, 32'h8000_0000, 16'($urandom()),
              16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd1, 32'h7fff_ffff, 16'($urandom()),
              16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd2, 32'd0, 16'($urandom()), 16'($urandom()));
    send_item(bcor_pkg::OP_TRANSFORM, 4'd4, 32'hffff_ffff, 16'($urandom()),
              16'($urandom()));
    s_tvalid <= 1'b0;

    // Random phases, each under its own register settings
    for (int p = 1; p <= 9; p++) begin
      wait_drain();
      case (p)
        1: apply_settings(-32, -32768, 31, 1'b1);
        2: apply_settings(31, 32767, 0, 1'b0);
        3: apply_settings(-17, -1, 20, 1'b1);
        4: apply_settings(6, 3, 10, 1'b0);
        5: apply_settings(0, 1, 8, 1'b0);
        default: apply_settings($urandom_range(0, 22) - 8, pick_value(16),
                                $urandom_range(0, 31), p[0]);
      endcase
      tx_gaps    = p[0];
      burst_left = 0;
      rx_style   = p % 3;
      // Output held off long enough for the pipeline to fill and backpressure
      if (p == 4) begin
        tx_gaps = 1'b0;
        rx_hold = 300;
      end
      repeat (110) begin
        if ($urandom_range(0, 3) == 0)
          send_item(bcor_pkg::OP_LOAD, 4'($urandom_range(0, 15)), $urandom(),
                    16'(pick_value(16)), 16'(pick_value(16)));
        else
          send_item(bcor_pkg::OP_TRANSFORM, 4'($urandom_range(0, 15)), pick_value(32),
                    16'($urandom()), 16'($urandom()));
      end
      s_tvalid <= 1'b0;
    end

    wait_drain();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
